### rtl/core/arss_pkg.sv
// ---------------------------------------------------------------------------
// arss_pkg: shared definitions for the autorange scale selector
// Widths, register indexes, defaults and sequencer state codes.
// ---------------------------------------------------------------------------
package arss_pkg;

    localparam int NUM_CH    = 3;
    localparam int CH_W      = 2;
    localparam int RD_W      = 32;
    localparam int FRAC_W    = 8;
    localparam int LIM_W     = 16;
    localparam int LVL_W     = 2;
    localparam int LCFG_W    = 3;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CMP_W     = RD_W + 1;
    localparam int OUT_W     = LVL_W + LIM_W + 1;
    localparam int OTDATA_W  = ((OUT_W + 7) / 8) * 8;

    localparam int DEF_HOLD_SAMPLES = 256;
    localparam int DEF_LEVELS       = 4;

    localparam logic [CFG_IDX_W-1:0] REG_THR0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LVL0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_END  = 3'd6;

    localparam logic [CH_W-1:0]   CH_UNUSED = 2'd3;
    localparam logic [LCFG_W-1:0] LVL_RESET = 3'd4;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_LOAD   = 8'b0000_0010,
        S_CHECK  = 8'b0000_0100,
        S_UP     = 8'b0000_1000,
        S_BELOW  = 8'b0001_0000,
        S_MAX    = 8'b0010_0000,
        S_DOWN   = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } state_t;

endpackage

### rtl/core/autorange_scale_selector.sv
// ---------------------------------------------------------------------------
// autorange_scale_selector: per-channel auto-ranging with hold-off
// Walks each channel's scale level up or down against its full-scale limits.
// ---------------------------------------------------------------------------
// One beat in, one beat out. A single signed comparator is shared by a small
// sequencer that walks the scale level one step per cycle. A channel 3 beat
// goes straight to the finish state. Any other beat is loaded and checked
// against its current limit; above it, the level steps up. Else, at a level
// above 0, the reading is compared with the next lower limit; below it, the
// peak is kept and the hold counts down, and once it expires the level steps
// down. The finish state waits while the output register is full, then loads
// it. s_tready is high only while the sequencer is idle; a finished result
// sits in the output register while the next beat is accepted.
// Channel 3 returns level 0, full scale 0, no change, and touches no state.
// Configuration is a plain write port: indexes 0..2 take the four 16-bit
// limits of a channel, 3..5 the number of levels in use of a channel.
module autorange_scale_selector
    import arss_pkg::*;
#(
    parameter int HOLD_SAMPLES = DEF_HOLD_SAMPLES,
    parameter int LEVELS       = DEF_LEVELS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [RD_W-1:0]       s_tdata,   // [31:0] reading
    input  logic [CH_W-1:0]       s_tuser,   // [1:0] channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OTDATA_W-1:0]   m_tdata,   // [1:0] scale_level, [17:2] full_scale,
                                             // [18] scale_changed, rest zero
    output logic [CH_W-1:0]       m_tuser    // [1:0] channel_out
);

    localparam int HOLD_W = $clog2(HOLD_SAMPLES + 1);
    localparam logic [HOLD_W-1:0] HOLD_INIT = HOLD_W'(HOLD_SAMPLES);
    localparam logic [LCFG_W-1:0] LVL_MAX   = LCFG_W'(LEVELS);

    // configuration and per-channel state
    logic [CFG_W-1:0]         thr_reg   [NUM_CH];
    logic [LCFG_W-1:0]        lcfg_reg  [NUM_CH];
    logic [LVL_W-1:0]         level_reg [NUM_CH];
    logic [HOLD_W-1:0]        hold_reg  [NUM_CH];
    logic signed [RD_W-1:0]   maxr_reg  [NUM_CH];

    // working registers
    state_t                   state_reg, state_next;
    logic [CH_W-1:0]          ch_reg;
    logic [1:0]               chi;
    logic signed [RD_W-1:0]   rd_reg;
    logic [LVL_W-1:0]         cur_reg, cur_next;
    logic [LVL_W-1:0]         start_reg;
    logic [LVL_W-1:0]         top_reg;
    logic [HOLD_W-1:0]        cnt_reg, cnt_next;
    logic signed [RD_W-1:0]   wmax_reg, wmax_next;
    logic                     expire_reg, expire_next;

    logic                     m_tvalid_reg;
    logic [OUT_W-1:0]         m_data_reg;
    logic [CH_W-1:0]          m_user_reg;

    logic                     s_acc;
    logic                     finish_go;

    // shared comparator
    logic [LVL_W-1:0]         lim_idx;
    logic [LIM_W-1:0]         lim_raw;
    logic signed [CMP_W-1:0]  cmp_a, cmp_b;
    logic                     cmp_gt, cmp_lt;

    // level clamp for the load step
    logic [LCFG_W-1:0]        lcfg_n;
    logic [LVL_W-1:0]         top_calc;
    logic [LVL_W-1:0]         lvl_in;

    logic [LIM_W-1:0]         fs_raw;

    assign chi = (ch_reg == CH_UNUSED) ? 2'd0 : ch_reg;

    always_comb begin
        if (lcfg_reg[chi] == '0) begin
            lcfg_n = LCFG_W'(1);
        end else if (lcfg_reg[chi] > LVL_MAX) begin
            lcfg_n = LVL_MAX;
        end else begin
            lcfg_n = lcfg_reg[chi];
        end
        top_calc = LVL_W'(lcfg_n - LCFG_W'(1));
        lvl_in   = (level_reg[chi] > top_calc) ? top_calc : level_reg[chi];
    end

    always_comb begin
        if (state_reg == S_BELOW || state_reg == S_DOWN) begin
            lim_idx = cur_reg - LVL_W'(1);
        end else begin
            lim_idx = cur_reg;
        end
        lim_raw = thr_reg[chi][LIM_W*lim_idx +: LIM_W];
        case (state_reg)
            S_MAX: begin
                cmp_a = CMP_W'(rd_reg);
                cmp_b = CMP_W'(wmax_reg);
            end
            S_DOWN: begin
                cmp_a = CMP_W'(wmax_reg);
                cmp_b = {{(CMP_W-LIM_W-FRAC_W){1'b0}}, lim_raw, {FRAC_W{1'b0}}};
            end
            default: begin
                cmp_a = CMP_W'(rd_reg);
                cmp_b = {{(CMP_W-LIM_W-FRAC_W){1'b0}}, lim_raw, {FRAC_W{1'b0}}};
            end
        endcase
        cmp_gt = cmp_a > cmp_b;
        cmp_lt = cmp_a < cmp_b;
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign finish_go = (state_reg == S_FINISH) && (!m_tvalid_reg || m_tready);
    assign fs_raw    = (ch_reg == CH_UNUSED) ? '0 : thr_reg[chi][LIM_W*cur_reg +: LIM_W];

    always_comb begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        cnt_next    = cnt_reg;
        wmax_next   = wmax_reg;
        expire_next = expire_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    cur_next   = '0;
                    state_next = (s_tuser == CH_UNUSED) ? S_FINISH : S_LOAD;
                end
            end
            S_LOAD: begin
                cur_next   = lvl_in;
                cnt_next   = hold_reg[chi];
                wmax_next  = maxr_reg[chi];
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (cmp_gt) begin
                    cnt_next  = HOLD_INIT;
                    wmax_next = '0;
                    if (cur_reg < top_reg) begin
                        cur_next   = cur_reg + LVL_W'(1);
                        state_next = S_UP;
                    end else begin
                        state_next = S_FINISH;
                    end
                end else if (cur_reg != '0) begin
                    state_next = S_BELOW;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_UP: begin
                if (cur_reg < top_reg && cmp_gt) begin
                    cur_next = cur_reg + LVL_W'(1);
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_BELOW: begin
                if (cmp_lt) begin
                    expire_next = (cnt_reg <= HOLD_W'(1));
                    if (cnt_reg > HOLD_W'(1)) begin
                        cnt_next = cnt_reg - HOLD_W'(1);
                    end
                    state_next = S_MAX;
                end else begin
                    cnt_next   = HOLD_INIT;
                    wmax_next  = '0;
                    state_next = S_FINISH;
                end
            end
            S_MAX: begin
                if (cmp_gt) begin
                    wmax_next = rd_reg;
                end
                state_next = expire_reg ? S_DOWN : S_FINISH;
            end
            S_DOWN: begin
                if (cur_reg != '0 && cmp_lt) begin
                    cur_next = cur_reg - LVL_W'(1);
                end else begin
                    cnt_next   = HOLD_INIT;
                    wmax_next  = '0;
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (finish_go) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_CH; i++) begin
                thr_reg[i]   <= '0;
                lcfg_reg[i]  <= LVL_RESET;
                level_reg[i] <= '0;
                hold_reg[i]  <= HOLD_INIT;
                maxr_reg[i]  <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                if (cfg_index < REG_LVL0) begin
                    thr_reg[cfg_index[1:0]] <= cfg_wr_data;
                end else if (cfg_index < REG_END) begin
                    lcfg_reg[2'(cfg_index - REG_LVL0)] <= cfg_wr_data[LCFG_W-1:0];
                end
            end
            if (finish_go) begin
                m_tvalid_reg <= 1'b1;
                if (ch_reg != CH_UNUSED) begin
                    level_reg[chi] <= cur_reg;
                    hold_reg[chi]  <= cnt_reg;
                    maxr_reg[chi]  <= wmax_reg;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        cnt_reg    <= cnt_next;
        wmax_reg   <= wmax_next;
        expire_reg <= expire_next;
        if (s_acc) begin
            ch_reg  <= s_tuser;
            rd_reg  <= s_tdata;
        end
        if (state_reg == S_LOAD) begin
            start_reg <= lvl_in;
            top_reg   <= top_calc;
        end
        if (finish_go) begin
            m_user_reg <= ch_reg;
            if (ch_reg == CH_UNUSED) begin
                m_data_reg <= '0;
            end else begin
                m_data_reg <= {(cur_reg != start_reg), fs_raw, cur_reg};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OTDATA_W-OUT_W){1'b0}}, m_data_reg};
    assign m_tuser  = m_user_reg;

    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHECK || state_reg == S_UP || state_reg == S_BELOW ||
         state_reg == S_MAX || state_reg == S_DOWN) |-> cur_reg <= top_reg)
        else $error("scale level walked past top level");

    a_unused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == CH_UNUSED) |-> m_tdata == '0)
        else $error("unused channel returned nonzero result");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_tready)
        else $error("input ready while a beat is in work");

    a_finish_loads_out: assert property (@(posedge aclk) disable iff (!aresetn)
        finish_go |=> (m_tvalid && s_tready))
        else $error("finished beat not presented on output");

endmodule

### verif/tb_autorange_scale_selector.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_autorange_scale_selector: self-checking bench for the autorange selector
// Streams channel readings through the block under random source bursts and
// sink stalls. Every accepted beat is run through a local scale predictor;
// each result beat is compared field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_autorange_scale_selector;
    import arss_pkg::*;

    localparam int HOLD       = DEF_HOLD_SAMPLES;
    localparam int MAX_LEVELS = DEF_LEVELS;
    localparam int N_PHASES   = 6;
    localparam int N_RANDOM   = 1750;
    localparam int MAX_PRINTS = 100;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic [RD_W-1:0] rd;
    } reading_t;

    typedef struct packed {
        logic [CH_W-1:0]  ch;
        logic [LVL_W-1:0] lvl;
        logic [LIM_W-1:0] fs;
        logic             chg;
    } scale_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_THROTTLE} rx_mode_t;
    typedef enum int {EP_NOISE, EP_CLIMB, EP_STEADY, EP_EDGE, EP_SPIKE, EP_DIP} episode_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [RD_W-1:0]      s_tdata     = '0;   // [31:0] reading
    logic [CH_W-1:0]      s_tuser     = '0;   // [1:0] channel
    logic                 m_tvalid;
    logic                 m_tready    = 1'b1;
    logic [OTDATA_W-1:0]  m_tdata;            // [1:0] level, [17:2] full scale, [18] changed
    logic [CH_W-1:0]      m_tuser;            // [1:0] channel_out

    // predictor copy of configuration and per-channel state
    logic [CFG_W-1:0]       thr_cfg    [NUM_CH];
    logic [LCFG_W-1:0]      lvl_cfg    [NUM_CH];
    logic [LVL_W-1:0]       cur_level  [NUM_CH];
    int                     hold_left  [NUM_CH];
    logic signed [RD_W-1:0] peak_below [NUM_CH];

    reading_t readings_to_send [$];
    scale_t   expected_scales  [$];
    int       readings_queued = 0;
    int       scales_checked  = 0;
    int       errors          = 0;
    int       burst_left      = 0;
    int       gap_left        = 0;
    rx_mode_t rx_mode         = RX_OPEN;
    int       rx_cycles       = 0;

    autorange_scale_selector #(
        .HOLD_SAMPLES (HOLD),
        .LEVELS       (MAX_LEVELS)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint scale_limit(int ch, int lvl);
        return longint'(thr_cfg[ch][lvl*LIM_W +: LIM_W]) * 256;
    endfunction

    function automatic int levels_in_use(int ch);
        int n;
        n = lvl_cfg[ch];
        if (n < 1) n = 1;
        if (n > MAX_LEVELS) n = MAX_LEVELS;
        return n;
    endfunction

    function automatic void restart_hold(int ch);
        hold_left[ch]  = HOLD;
        peak_below[ch] = '0;
    endfunction

    function automatic scale_t select_scale(logic [CH_W-1:0] ch, logic signed [RD_W-1:0] rd);
        scale_t r;
        int     top, lvl, start;
        bit     expired;
        r    = '0;
        r.ch = ch;
        if (ch >= NUM_CH) return r;
        top   = levels_in_use(ch) - 1;
        lvl   = (cur_level[ch] > top) ? top : cur_level[ch];
        start = lvl;
        if (longint'(rd) > scale_limit(ch, lvl)) begin
            while (lvl < top && longint'(rd) > scale_limit(ch, lvl)) lvl++;
            restart_hold(ch);
        end else if (lvl > 0) begin
            if (longint'(rd) < scale_limit(ch, lvl - 1)) begin
                expired = hold_left[ch] <= 1;
                if (!expired) hold_left[ch]--;
                if (rd > peak_below[ch]) peak_below[ch] = rd;
                if (expired) begin
                    while (lvl > 0 && longint'(peak_below[ch]) < scale_limit(ch, lvl - 1))
                        lvl--;
                    restart_hold(ch);
                end
            end else begin
                restart_hold(ch);
            end
        end
        cur_level[ch] = LVL_W'(lvl);
        r.lvl = LVL_W'(lvl);
        r.fs  = thr_cfg[ch][lvl*LIM_W +: LIM_W];
        r.chg = (lvl != start);
        return r;
    endfunction

    // random reading inside level k of channel ch: above level k-1, not above level k
    function automatic logic [RD_W-1:0] reading_at(int ch, int k);
        longint lo, hi, v;
        lo = (k == 0) ? -65536 : scale_limit(ch, k - 1) + 1;
        hi = scale_limit(ch, k);
        if (hi <= lo) return RD_W'(hi);
        v = lo + longint'($urandom_range(int'(hi - lo)));
        return RD_W'(v);
    endfunction

    function automatic logic [RD_W-1:0] above_all(int ch);
        return RD_W'(scale_limit(ch, MAX_LEVELS - 1) + longint'($urandom_range(1, 1 << 20)));
    endfunction

    function automatic logic [CFG_W-1:0] random_limits();
        logic [LIM_W-1:0] v [4];
        int               pick, acc, step;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        if (pick == 2) return {$urandom(), $urandom()};
        step = (pick == 3) ? 16000 : 3000;
        acc  = $urandom_range(0, step);
        for (int i = 0; i < 4; i++) begin
            v[i] = LIM_W'(acc);
            acc  = acc + $urandom_range(0, step);
        end
        if (pick == 4) v[3] = '1;
        return {v[3], v[2], v[1], v[0]};
    endfunction

    function automatic logic [CFG_W-1:0] random_levels();
        int pick;
        pick = $urandom_range(0, 11);
        return (pick < 8) ? CFG_W'(pick) : CFG_W'(MAX_LEVELS);
    endfunction

    task automatic queue_reading(logic [CH_W-1:0] ch, logic [RD_W-1:0] rd);
        reading_t item;
        item.ch = ch;
        item.rd = rd;
        readings_to_send.push_back(item);
        readings_queued++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        if (idx < REG_LVL0) thr_cfg[idx] = data;
        else if (idx < REG_END) lvl_cfg[idx - REG_LVL0] = data[LCFG_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        while (scales_checked != readings_queued) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic report_mismatch(string what, logic [LIM_W-1:0] got, logic [LIM_W-1:0] want);
        if (errors < MAX_PRINTS)
            $display("ERROR at %0t, result %0d: %s got 0x%0h expected 0x%0h",
                     $time, scales_checked, what, got, want);
        errors++;
    endtask

    // spike to the top, then a long run of low readings so the hold can expire
    task automatic hold_run(int c);
        int top, k, len, brk, other;
        top = levels_in_use(c) - 1;
        k   = (top > 1) ? $urandom_range(0, top - 2) : 0;
        len = HOLD - 8 + $urandom_range(0, 24);
        brk = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len - 1) : -1;
        queue_reading(CH_W'(c), above_all(c));
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                other = (c + $urandom_range(1, 2)) % NUM_CH;
                queue_reading(CH_W'(other),
                              reading_at(other, $urandom_range(0, levels_in_use(other) - 1)));
            end
            if (i == brk)
                queue_reading(CH_W'(c), reading_at(c, top));
            else
                queue_reading(CH_W'(c), reading_at(c, $urandom_range(0, k)) - 1);
        end
    endtask

    task automatic random_episode();
        int       c, k, top;
        episode_t ep;
        c   = $urandom_range(0, NUM_CH - 1);
        top = levels_in_use(c) - 1;
        k   = $urandom_range(0, top);
        ep  = episode_t'($urandom_range(EP_NOISE, EP_DIP));
        case (ep)
            EP_NOISE: begin
                repeat ($urandom_range(1, 4)) queue_reading(CH_W'($urandom_range(0, 3)), $urandom());
            end
            EP_CLIMB: begin
                repeat ($urandom_range(1, 4))
                    queue_reading(CH_W'(c), reading_at(c, $urandom_range(0, top)) + 1);
            end
            EP_STEADY: begin
                repeat ($urandom_range(5, 20)) queue_reading(CH_W'(c), reading_at(c, k));
            end
            EP_EDGE: begin
                queue_reading(CH_W'(c),
                              RD_W'(scale_limit(c, k) + longint'(int'($urandom_range(0, 2)) - 1)));
            end
            EP_SPIKE: begin
                queue_reading(CH_W'(c), above_all(c));
            end
            default: begin
                repeat ($urandom_range(3, 30)) queue_reading(CH_W'(c), reading_at(c, 0) - 1);
            end
        endcase
    endtask

    // source: bursts of beats separated by random gaps
    always @(posedge aclk) begin
        reading_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_scales.push_back(select_scale(s_tuser, s_tdata));
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (readings_to_send.size() != 0) begin
                    item = readings_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= item.rd;
                    s_tuser  <= item.ch;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink: check result beats, stall on a random mode that is redrawn whenever its countdown runs out
    always @(posedge aclk) begin
        scale_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_scales.size() == 0) begin
                report_mismatch("unexpected result beat, channel_out", LIM_W'(m_tuser), '0);
            end else begin
                want = expected_scales.pop_front();
                if (m_tuser !== want.ch)
                    report_mismatch("channel_out", LIM_W'(m_tuser), LIM_W'(want.ch));
                if (m_tdata[1:0] !== want.lvl)
                    report_mismatch("scale_level", LIM_W'(m_tdata[1:0]), LIM_W'(want.lvl));
                if (m_tdata[17:2] !== want.fs)
                    report_mismatch("full_scale", m_tdata[17:2], want.fs);
                if (m_tdata[18] !== want.chg)
                    report_mismatch("scale_changed", LIM_W'(m_tdata[18]), LIM_W'(want.chg));
                scales_checked++;
            end
        end
        if (rx_cycles == 0) begin
            rx_mode   = rx_mode_t'($urandom_range(RX_OPEN, RX_THROTTLE));
            rx_cycles = $urandom_range(50, 400);
        end else begin
            rx_cycles--;
        end
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
            default:   m_tready <= (rx_cycles % 13) > 9;
        endcase
    end

    initial begin
        int target;
        for (int c = 0; c < NUM_CH; c++) begin
            thr_cfg[c]   = '0;
            lvl_cfg[c]   = LVL_RESET;
            cur_level[c] = '0;
            restart_hold(c);
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: ch0 ascending with max top limit, ch1 out of order, ch2 tiny limits
        write_reg(CFG_IDX_W'(REG_THR0 + 0), {16'hFFFF, 16'd3000, 16'd1000, 16'd10});
        write_reg(CFG_IDX_W'(REG_THR0 + 1), {16'd50, 16'd2000, 16'd100, 16'd500});
        write_reg(CFG_IDX_W'(REG_THR0 + 2), {16'd3, 16'd2, 16'd1, 16'd0});
        write_reg(CFG_IDX_W'(REG_LVL0 + 0), CFG_W'(4));
        write_reg(CFG_IDX_W'(REG_LVL0 + 1), CFG_W'(7));
        write_reg(CFG_IDX_W'(REG_LVL0 + 2), CFG_W'(0));
        queue_reading(2'd0, 32'h8000_0000);
        queue_reading(2'd0, 32'(10 * 256));
        queue_reading(2'd0, 32'(10 * 256 + 1));
        queue_reading(2'd0, 32'h7FFF_FFFF);
        queue_reading(2'd0, 32'h7FFF_FFFF);
        queue_reading(2'd0, 32'd0);
        queue_reading(2'd1, 32'(300 * 256));
        queue_reading(2'd1, 32'(600 * 256));
        queue_reading(2'd1, 32'(3000 * 256));
        queue_reading(2'd1, 32'(60 * 256));
        queue_reading(2'd1, 32'(10 * 256));
        queue_reading(2'd2, 32'(5 * 256));
        queue_reading(CH_UNUSED, $urandom());
        queue_reading(CH_UNUSED, 32'h8000_0000);
        wait_idle();

        // lowered level count on a channel sitting at its top level
        write_reg(CFG_IDX_W'(REG_LVL0 + 0), CFG_W'(2));
        write_reg(CFG_IDX_W'(REG_LVL0 + 1), CFG_W'(6));
        write_reg(CFG_IDX_W'(REG_LVL0 + 2), CFG_W'(5));
        queue_reading(2'd0, 32'(500 * 256));
        queue_reading(2'd0, 32'h7FFF_FFFF);
        queue_reading(2'd2, 32'(2 * 256 + 128));
        queue_reading(2'd2, 32'hFFFF_FFFF);
        queue_reading(2'd1, 32'd0);

        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            for (int c = 0; c < NUM_CH; c++) begin
                write_reg(CFG_IDX_W'(REG_THR0 + c), random_limits());
                write_reg(CFG_IDX_W'(REG_LVL0 + c), random_levels());
            end
            target = readings_queued + N_RANDOM / N_PHASES;
            hold_run($urandom_range(0, NUM_CH - 1));
            while (readings_queued < target) random_episode();
        end
        wait_idle();

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
